// ===== src/walc_pkg.sv =====
// Package for the wall approach velocity controller.
// Holds register layout, reset values, field widths and width helpers.
// No dependencies; every other file depends on it.
`default_nettype none

package walc_pkg;

   localparam int SENSOR_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 12;

   localparam int OUT_BITS       = 14;
   localparam int SPEED_BITS     = 13;
   localparam int CSR_DATA_BITS  = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int GAIN_SHIFT     = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_REAR_SETPOINT    = 3'd0,
      REG_NEAR_THRESHOLD   = 3'd1,
      REG_LEFT_OFFSET      = 3'd2,
      REG_FAST_SPEED       = 3'd3,
      REG_SLOW_SPEED       = 3'd4,
      REG_X_GAIN           = 3'd5,
      REG_YAW_GAIN_MOVING  = 3'd6,
      REG_YAW_GAIN_STOPPED = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0]           rear_setpoint;
      logic [15:0]           near_threshold;
      logic [11:0]           left_offset;
      logic [SPEED_BITS-1:0] fast_speed;
      logic [SPEED_BITS-1:0] slow_speed;
      logic [15:0]           x_gain;
      logic [16:0]           yaw_gain_moving;
      logic [16:0]           yaw_gain_stopped;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rear_setpoint:    16'd13500,
      near_threshold:   16'd10000,
      left_offset:      12'd800,
      fast_speed:       13'd5325,
      slow_speed:       13'd1229,
      x_gain:           16'd53687,
      yaw_gain_moving:  17'd32768,
      yaw_gain_stopped: 17'd61441
   };

   // Classification flags that travel with each queued request.
   typedef struct packed {
      logic read_ok;
      logic is_left;
      logic stopped;
   } flags_type;

   localparam int FLAGS_BITS = 3;

   // Width of the offset-corrected left value.
   function automatic int lsum_bits(input int sensor_bits);
      return ((sensor_bits > 12) ? sensor_bits : 12) + 1;
   endfunction

   // Width of one queue entry: flags, speed, left value, right value.
   function automatic int entry_bits(input int sensor_bits);
      return FLAGS_BITS + SPEED_BITS + lsum_bits(sensor_bits) + sensor_bits;
   endfunction

endpackage

`default_nettype wire

// ===== src/walc_ifs.sv =====
// Request and response channel interfaces of the wall approach controller.
// Depends on walc_pkg for default widths.
`default_nettype none

interface walc_req_if #(
   parameter int SensorBits = walc_pkg::SENSOR_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  read_ok;
   logic                  is_left;
   logic [SensorBits-1:0] rear_left;
   logic [SensorBits-1:0] rear_right;
   logic [SensorBits-1:0] side_right_slow;
   logic [SensorBits-1:0] side_right_stop;
   logic [SensorBits-1:0] side_left_slow;
   logic [SensorBits-1:0] side_left_stop;

   modport source (
      output valid, read_ok, is_left, rear_left, rear_right,
             side_right_slow, side_right_stop, side_left_slow, side_left_stop,
      input  ready
   );
   modport sink (
      input  valid, read_ok, is_left, rear_left, rear_right,
             side_right_slow, side_right_stop, side_left_slow, side_left_stop,
      output ready
   );
endinterface

interface walc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                command_valid;
   logic signed [walc_pkg::OUT_BITS-1:0] vel_forward;
   logic signed [walc_pkg::OUT_BITS-1:0] vel_side;
   logic signed [walc_pkg::OUT_BITS-1:0] yaw_rate;
   logic                                arrived;

   modport source (
      output valid, command_valid, vel_forward, vel_side, yaw_rate, arrived,
      input  ready
   );
   modport sink (
      input  valid, command_valid, vel_forward, vel_side, yaw_rate, arrived,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/wall_approach_velocity_controller.sv =====
// Top level of the wall approach velocity controller: register file and
// the front end, queue and back end. Depends on walc_pkg, walc_ifs and submodules.
//
//   port        dir   kind                 carries
//   req_chan    in    valid/ready stream   one sensor sample set per request
//   rsp_chan    out   valid/ready stream   one velocity command per request
//   csr_*       in    write-only port      eight tuning registers
//
// Throughput is one request per cycle while rsp_chan.ready stays high; the rear
// filters are a registered recurrence in the front end and the back end is fully
// pipelined. A request passes through the queue entry, the error stage, the
// multiply stage, then the clamp/output register before its response is valid.
// Reset clears the filters, restores register defaults and empties the queue.
// A stalled response holds the back end; the two-entry queue keeps the
// front end accepting until it fills, then req_chan.ready drops.
`default_nettype none

module wall_approach_velocity_controller #(
   parameter int SENSOR_BITS   = walc_pkg::SENSOR_BITS_DEFAULT,
   parameter int FRACTION_BITS = walc_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   walc_req_if.sink                                  req_chan,
   walc_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [walc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [walc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import walc_pkg::*;

   localparam int EW = entry_bits(SENSOR_BITS);

   cfg_type       cfg_ff, cfg_in;
   logic          push_valid, push_ready;
   logic [EW-1:0] push_data;
   logic          pop_valid, pop_ready;
   logic [EW-1:0] pop_data;

   // Register file: mask each write to its register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_REAR_SETPOINT:    cfg_in.rear_setpoint    = csr_wdata[15:0];
            REG_NEAR_THRESHOLD:   cfg_in.near_threshold   = csr_wdata[15:0];
            REG_LEFT_OFFSET:      cfg_in.left_offset      = csr_wdata[11:0];
            REG_FAST_SPEED:       cfg_in.fast_speed       = csr_wdata[SPEED_BITS-1:0];
            REG_SLOW_SPEED:       cfg_in.slow_speed       = csr_wdata[SPEED_BITS-1:0];
            REG_X_GAIN:           cfg_in.x_gain           = csr_wdata[15:0];
            REG_YAW_GAIN_MOVING:  cfg_in.yaw_gain_moving  = csr_wdata[16:0];
            REG_YAW_GAIN_STOPPED: cfg_in.yaw_gain_stopped = csr_wdata[16:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: filter, classify and push one entry per request.
   walc_front #(
      .SENSOR_BITS (SENSOR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple the two halves so each can stall on its own.
   walc_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // Back end: scale, clamp and hold the response.
   walc_back #(
      .SENSOR_BITS   (SENSOR_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== src/walc_front.sv =====
// Front end: accepts sensor requests, runs the rear filters, picks the
// sideways speed and pushes one entry per request. Depends on walc_pkg, walc_ifs.
`default_nettype none

module walc_front #(
   parameter int SENSOR_BITS = walc_pkg::SENSOR_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   walc_req_if.sink                   req_chan,
   input  wire walc_pkg::cfg_type     cfg,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output logic [walc_pkg::entry_bits(SENSOR_BITS)-1:0] push_data
);
   import walc_pkg::*;

   localparam int SW   = SENSOR_BITS + 5;
   localparam int YW   = SENSOR_BITS + 3;
   localparam int MW   = YW - 2;
   localparam int LW   = lsum_bits(SENSOR_BITS);
   localparam int CMPW = (SENSOR_BITS > 16) ? SENSOR_BITS : 16;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / 64'd5);

   logic [SENSOR_BITS-1:0] filtered_left_ff, filtered_left_in;
   logic [SENSOR_BITS-1:0] filtered_right_ff, filtered_right_in;
   logic [SENSOR_BITS-1:0] side_slow, side_stop;
   logic                   slow_hit, stop_hit;
   logic [SPEED_BITS-1:0]  speed;
   logic [LW-1:0]          left_value;
   flags_type              flags;
   logic                   accept;

   // floor((sample + 19*old) / 20): divide by 4, then by 5 via reciprocal
   function automatic logic [SENSOR_BITS-1:0] filt(
      input logic [SENSOR_BITS-1:0] sample,
      input logic [SENSOR_BITS-1:0] old
   );
      logic [SW-1:0]     sum;
      logic [YW-1:0]     y;
      logic [YW+MW-1:0]  prod;
      logic [MW-1:0]     q0;
      logic [YW-1:0]     r;
      sum  = SW'(sample) + (SW'(old) << 4) + (SW'(old) << 1) + SW'(old);
      y    = sum[SW-1:2];
      prod = (YW+MW)'(y) * (YW+MW)'(RECIP);
      q0   = prod[YW+MW-1:YW];
      r    = y - (YW'(q0) << 2) - YW'(q0);
      return (r >= YW'(5)) ? SENSOR_BITS'(q0 + MW'(1)) : SENSOR_BITS'(q0);
   endfunction

   // Hold ready low during reset so no request is taken and lost.
   assign accept         = req_chan.valid && push_ready && !reset;
   assign req_chan.ready = push_ready && !reset;
   assign push_valid     = req_chan.valid;

   always_comb begin
      filtered_left_in  = filtered_left_ff;
      filtered_right_in = filtered_right_ff;
      if (accept && req_chan.read_ok) begin
         filtered_left_in  = filt(req_chan.rear_left, filtered_left_ff);
         filtered_right_in = filt(req_chan.rear_right, filtered_right_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filtered_left_ff  <= '0;
         filtered_right_ff <= '0;
      end else begin
         filtered_left_ff  <= filtered_left_in;
         filtered_right_ff <= filtered_right_in;
      end
   end

   always_comb begin
      side_slow = req_chan.is_left ? req_chan.side_left_slow : req_chan.side_right_slow;
      side_stop = req_chan.is_left ? req_chan.side_left_stop : req_chan.side_right_stop;
      slow_hit  = CMPW'(side_slow) > CMPW'(cfg.near_threshold);
      stop_hit  = CMPW'(side_stop) > CMPW'(cfg.near_threshold);
      speed     = cfg.fast_speed;
      if (slow_hit) begin
         speed = cfg.slow_speed;
      end
      if (stop_hit) begin
         speed = '0;
      end
      left_value    = LW'(filtered_left_in) + LW'(cfg.left_offset);
      flags.read_ok = req_chan.read_ok;
      flags.is_left = req_chan.is_left;
      flags.stopped = (speed == '0);
      push_data     = {flags, speed, left_value, filtered_right_in};
   end

   // An invalid read must leave both filters untouched.
   a_bad_read_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.read_ok) |=>
         ($stable(filtered_left_ff) && $stable(filtered_right_ff)))
      else $error("filter moved on an invalid read");

endmodule

`default_nettype wire

// ===== src/walc_queue.sv =====
// Two-entry register queue between front end and back end.
// Depends on walc_pkg only for the file convention; width is a parameter.
`default_nettype none

module walc_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);
   import walc_pkg::*;

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count out of range");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
      else $error("queue head changed while stalled");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == 2'($past(count_ff) + 2'd1)))
      else $error("queue lost a request");

endmodule

`default_nettype wire

// ===== src/walc_back.sv =====
// Back end: three-stage pipeline that forms errors, scales by the gains,
// clamps and drives the response register. Depends on walc_pkg, walc_ifs.
`default_nettype none

module walc_back #(
   parameter int SENSOR_BITS   = walc_pkg::SENSOR_BITS_DEFAULT,
   parameter int FRACTION_BITS = walc_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire walc_pkg::cfg_type     cfg,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire logic [walc_pkg::entry_bits(SENSOR_BITS)-1:0] pop_data,
   walc_rsp_if.source                 rsp_chan
);
   import walc_pkg::*;

   localparam int LW      = lsum_bits(SENSOR_BITS);
   localparam int DW      = (LW > 16) ? LW : 16;
   localparam int YPW     = LW + 1;
   localparam int PFW     = (DW > FRACTION_BITS + 1) ? DW : FRACTION_BITS + 1;
   localparam int PYW     = (YPW > FRACTION_BITS + 1) ? YPW : FRACTION_BITS + 1;
   localparam int FWD_LIM = 1 << FRACTION_BITS;
   localparam int YAW_LIM = (127 * (1 << FRACTION_BITS) + 50) / 100;

   // queue entry fields
   flags_type              q_flags;
   logic [SPEED_BITS-1:0]  q_speed;
   logic [LW-1:0]          q_left;
   logic [SENSOR_BITS-1:0] q_right;
   logic [LW-1:0]          q_mean;
   logic [LW:0]            q_sum;

   // stage 1: error magnitudes and signs
   logic                   s1_valid_ff;
   flags_type              s1_flags_ff;
   logic [SPEED_BITS-1:0]  s1_speed_ff;
   logic [DW-1:0]          s1_fwd_mag_ff, s1_fwd_mag_in;
   logic                   s1_fwd_neg_ff, s1_fwd_neg_in;
   logic [LW-1:0]          s1_yaw_mag_ff, s1_yaw_mag_in;
   logic                   s1_yaw_neg_ff, s1_yaw_neg_in;
   logic [16:0]            s1_gain_ff;

   // stage 2: scaled products
   logic                   s2_valid_ff;
   flags_type              s2_flags_ff;
   logic [SPEED_BITS-1:0]  s2_speed_ff;
   logic [DW-1:0]          s2_fwd_p_ff;
   logic                   s2_fwd_neg_ff;
   logic [YPW-1:0]         s2_yaw_p_ff;
   logic                   s2_yaw_neg_ff;
   logic [DW+15:0]         fwd_prod;
   logic [LW+16:0]         yaw_prod;

   // stage 3: response register
   logic                   s3_valid_ff;
   logic                   out_cmd_ff, out_cmd_in;
   logic [OUT_BITS-1:0]    out_fwd_ff, out_fwd_in;
   logic [OUT_BITS-1:0]    out_side_ff, out_side_in;
   logic [OUT_BITS-1:0]    out_yaw_ff, out_yaw_in;
   logic                   out_arr_ff, out_arr_in;
   logic [PFW-1:0]         fwd_clamped;
   logic [PYW-1:0]         yaw_clamped;
   logic [OUT_BITS-1:0]    fwd_m, yaw_m, side_m;

   logic s1_en, s2_en, s3_en;

   assign s3_en     = !s3_valid_ff || rsp_chan.ready;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign pop_ready = s1_en;

   // stage 1 logic
   always_comb begin
      {q_flags, q_speed, q_left, q_right} = pop_data;
      q_sum  = (LW+1)'(q_left) + (LW+1)'(q_right);
      q_mean = q_sum[LW:1];
      s1_fwd_neg_in = DW'(q_mean) > DW'(cfg.rear_setpoint);
      s1_fwd_mag_in = s1_fwd_neg_in ? (DW'(q_mean) - DW'(cfg.rear_setpoint))
                                    : (DW'(cfg.rear_setpoint) - DW'(q_mean));
      s1_yaw_neg_in = LW'(q_right) > q_left;
      s1_yaw_mag_in = s1_yaw_neg_in ? (LW'(q_right) - q_left) : (q_left - LW'(q_right));
   end

   // stage 2 logic
   always_comb begin
      fwd_prod = (DW+16)'(s1_fwd_mag_ff) * (DW+16)'(cfg.x_gain);
      yaw_prod = (LW+17)'(s1_yaw_mag_ff) * (LW+17)'(s1_gain_ff);
   end

   // stage 3 logic: clamp magnitude, then apply the sign in 14 bits
   always_comb begin
      fwd_clamped = (PFW'(s2_fwd_p_ff) > PFW'(FWD_LIM)) ? PFW'(FWD_LIM) : PFW'(s2_fwd_p_ff);
      yaw_clamped = (PYW'(s2_yaw_p_ff) > PYW'(YAW_LIM)) ? PYW'(YAW_LIM) : PYW'(s2_yaw_p_ff);
      fwd_m  = fwd_clamped[OUT_BITS-1:0];
      yaw_m  = yaw_clamped[OUT_BITS-1:0];
      side_m = OUT_BITS'(s2_speed_ff);
      out_cmd_in  = s2_flags_ff.read_ok;
      out_arr_in  = s2_flags_ff.read_ok && s2_flags_ff.stopped;
      out_fwd_in  = s2_fwd_neg_ff ? (OUT_BITS'(0) - fwd_m) : fwd_m;
      out_yaw_in  = s2_yaw_neg_ff ? (OUT_BITS'(0) - yaw_m) : yaw_m;
      out_side_in = s2_flags_ff.is_left ? side_m : (OUT_BITS'(0) - side_m);
      if (!s2_flags_ff.read_ok) begin
         out_fwd_in  = '0;
         out_yaw_in  = '0;
         out_side_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= pop_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_flags_ff   <= q_flags;
         s1_speed_ff   <= q_speed;
         s1_fwd_mag_ff <= s1_fwd_mag_in;
         s1_fwd_neg_ff <= s1_fwd_neg_in;
         s1_yaw_mag_ff <= s1_yaw_mag_in;
         s1_yaw_neg_ff <= s1_yaw_neg_in;
         s1_gain_ff    <= q_flags.stopped ? cfg.yaw_gain_stopped : cfg.yaw_gain_moving;
      end
      if (s2_en) begin
         s2_flags_ff   <= s1_flags_ff;
         s2_speed_ff   <= s1_speed_ff;
         s2_fwd_p_ff   <= fwd_prod[DW+15:GAIN_SHIFT];
         s2_fwd_neg_ff <= s1_fwd_neg_ff;
         s2_yaw_p_ff   <= yaw_prod[LW+16:GAIN_SHIFT];
         s2_yaw_neg_ff <= s1_yaw_neg_ff;
      end
      if (s3_en) begin
         out_cmd_ff  <= out_cmd_in;
         out_fwd_ff  <= out_fwd_in;
         out_side_ff <= out_side_in;
         out_yaw_ff  <= out_yaw_in;
         out_arr_ff  <= out_arr_in;
      end
   end

   assign rsp_chan.valid         = s3_valid_ff;
   assign rsp_chan.command_valid = out_cmd_ff;
   assign rsp_chan.vel_forward   = out_fwd_ff;
   assign rsp_chan.vel_side      = out_side_ff;
   assign rsp_chan.yaw_rate      = out_yaw_ff;
   assign rsp_chan.arrived       = out_arr_ff;

   // A response for an invalid read carries no motion.
   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.command_valid) |->
         (out_fwd_ff == '0 && out_side_ff == '0 && out_yaw_ff == '0 && !out_arr_ff))
      else $error("motion on an invalid read");

endmodule

`default_nettype wire

// ===== tb/tb_wall_approach_velocity_controller.sv =====
// Self-checking testbench for wall_approach_velocity_controller: drives sensor requests,
// tuning register writes and response stalls, and checks every velocity command in order.
// Depends on walc_pkg, walc_ifs and the controller RTL; reads no files.

module tb_wall_approach_velocity_controller;

   import walc_pkg::*;

   localparam int SENSOR_BITS   = SENSOR_BITS_DEFAULT;
   localparam int FRACTION_BITS = FRACTION_BITS_DEFAULT;

   // Command limits: +-1.0 forward, +-1.27 yaw, both in output fraction units.
   localparam longint FWD_LIMIT = longint'(1) << FRACTION_BITS;
   localparam longint YAW_LIMIT = ((longint'(127) << FRACTION_BITS) + 50) / 100;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 16;

   localparam logic [SENSOR_BITS-1:0] FULL     = '1;
   localparam logic [SENSOR_BITS-1:0] NONE     = '0;
   localparam logic [SENSOR_BITS-1:0] THR_AT   = 16'd10000;
   localparam logic [SENSOR_BITS-1:0] THR_OVER = 16'd10001;

   typedef struct packed {
      logic                   read_ok;
      logic                   is_left;
      logic [SENSOR_BITS-1:0] rear_left;
      logic [SENSOR_BITS-1:0] rear_right;
      logic [SENSOR_BITS-1:0] side_right_slow;
      logic [SENSOR_BITS-1:0] side_right_stop;
      logic [SENSOR_BITS-1:0] side_left_slow;
      logic [SENSOR_BITS-1:0] side_left_stop;
   } sample_set_type;

   typedef struct packed {
      logic                       command_valid;
      logic signed [OUT_BITS-1:0] vel_forward;
      logic signed [OUT_BITS-1:0] vel_side;
      logic signed [OUT_BITS-1:0] yaw_rate;
      logic                       arrived;
   } command_type;

   // One directed request; the command is typed in only where typed is set.
   typedef struct {
      logic                   ok;
      logic                   left;
      logic [SENSOR_BITS-1:0] rear_l;
      logic [SENSOR_BITS-1:0] rear_r;
      logic [SENSOR_BITS-1:0] r_slow;
      logic [SENSOR_BITS-1:0] r_stop;
      logic [SENSOR_BITS-1:0] l_slow;
      logic [SENSOR_BITS-1:0] l_stop;
      bit                     typed;
      command_type            want;
   } directed_row_type;

   // Rows up to the first nonzero rear sample keep both filters at zero, so with
   // reset tuning L = 800 and R = 0: forward saturates, yaw is 400 moving and
   // 750 stopped.
   directed_row_type directed_rows [23] = '{
      // rejected read with every field high, then with every field low
      '{1'b0, 1'b1, FULL, FULL, FULL, FULL, FULL, FULL, 1'b1, '0},
      '{1'b0, 1'b0, NONE, NONE, NONE, NONE, NONE, NONE, 1'b1, '0},
      // fast speed, both directions
      '{1'b1, 1'b1, NONE, NONE, NONE, NONE, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, 14'sd5325, 14'sd400, 1'b0}},
      '{1'b1, 1'b0, NONE, NONE, NONE, NONE, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, -14'sd5325, 14'sd400, 1'b0}},
      // slow sensor just over and exactly at the threshold
      '{1'b1, 1'b1, NONE, NONE, NONE, NONE, THR_OVER, NONE, 1'b1,
        '{1'b1, 14'sd4096, 14'sd1229, 14'sd400, 1'b0}},
      '{1'b1, 1'b1, NONE, NONE, NONE, NONE, THR_AT, NONE, 1'b1,
        '{1'b1, 14'sd4096, 14'sd5325, 14'sd400, 1'b0}},
      // stop wins over slow, then right-side slow alone and stop alone
      '{1'b1, 1'b1, NONE, NONE, NONE, NONE, FULL, THR_OVER, 1'b1,
        '{1'b1, 14'sd4096, 14'sd0, 14'sd750, 1'b1}},
      '{1'b1, 1'b0, NONE, NONE, FULL, NONE, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, -14'sd1229, 14'sd400, 1'b0}},
      '{1'b1, 1'b0, NONE, NONE, NONE, FULL, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, 14'sd0, 14'sd750, 1'b1}},
      // sensors of the unselected side are ignored; readings at the threshold do not trigger
      '{1'b1, 1'b0, NONE, NONE, NONE, NONE, FULL, FULL, 1'b1,
        '{1'b1, 14'sd4096, -14'sd5325, 14'sd400, 1'b0}},
      '{1'b1, 1'b1, NONE, NONE, FULL, FULL, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, 14'sd5325, 14'sd400, 1'b0}},
      '{1'b1, 1'b0, NONE, NONE, THR_AT, THR_AT, NONE, NONE, 1'b1,
        '{1'b1, 14'sd4096, -14'sd5325, 14'sd400, 1'b0}},
      // full-scale rear samples walk the filters up
      '{1'b1, 1'b1, FULL, NONE, NONE, NONE, NONE, NONE, 1'b0, '0},
      '{1'b1, 1'b1, FULL, FULL, NONE, NONE, NONE, NONE, 1'b0, '0},
      '{1'b1, 1'b0, FULL, FULL, THR_OVER, NONE, NONE, NONE, 1'b0, '0},
      '{1'b1, 1'b1, FULL, FULL, NONE, NONE, NONE, FULL, 1'b0, '0},
      '{1'b1, 1'b0, FULL, FULL, FULL, THR_OVER, NONE, NONE, 1'b0, '0},
      '{1'b1, 1'b1, FULL, FULL, NONE, NONE, NONE, NONE, 1'b0, '0},
      // a rejected read must leave the filters alone
      '{1'b0, 1'b1, FULL, FULL, NONE, NONE, NONE, NONE, 1'b1, '0},
      // right ahead of left: negative yaw
      '{1'b1, 1'b0, NONE, FULL, NONE, NONE, NONE, NONE, 1'b0, '0},
      // alternating bit patterns, then both rear samples at the setpoint
      '{1'b1, 1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
        1'b0, '0},
      '{1'b1, 1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
        1'b0, '0},
      '{1'b1, 1'b1, 16'd13500, 16'd13500, NONE, NONE, FULL, NONE, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   walc_req_if #(.SensorBits(SENSOR_BITS)) req_chan_if ();
   walc_rsp_if                             rsp_chan_if ();

   wall_approach_velocity_controller #(
      .SENSOR_BITS  (SENSOR_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if),
      .rsp_chan (rsp_chan_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state: a copy of the tuning registers and of both rear filters.
   cfg_type                cfg_mirror = CFG_RESET;
   logic [SENSOR_BITS-1:0] filt_left  = '0;
   logic [SENSOR_BITS-1:0] filt_right = '0;

   // Commands owed by the block, oldest first.
   command_type pending_commands [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit calm           = 1'b0;   // no idling on either side
   int rear_level_l;
   int rear_level_r;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // trunc(v * gain / 65536), rounded toward zero
   function automatic longint scale_by_gain(input longint v, input longint gain);
      longint mag;
      longint prod;
      mag  = (v < 0) ? -v : v;
      prod = (mag * gain) >> GAIN_SHIFT;
      return (v < 0) ? -prod : prod;
   endfunction

   function automatic longint clamp_mag(input longint v, input longint lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   // Advance the filters and work out the command for one accepted request.
   function automatic command_type predict_command(input sample_set_type s);
      command_type            c;
      longint                 lv, rv, mean_dev, fwd, yaw, speed, side;
      logic [SENSOR_BITS-1:0] slow_rd, stop_rd;
      longint                 gain;
      c = '0;
      if (s.read_ok) begin
         filt_left  = SENSOR_BITS'((longint'(s.rear_left) + 19 * longint'(filt_left)) / 20);
         filt_right = SENSOR_BITS'((longint'(s.rear_right) + 19 * longint'(filt_right)) / 20);
         // the offset applies to this command only, never to the stored filter
         lv = longint'(filt_left) + longint'(cfg_mirror.left_offset);
         rv = longint'(filt_right);

         slow_rd = s.is_left ? s.side_left_slow : s.side_right_slow;
         stop_rd = s.is_left ? s.side_left_stop : s.side_right_stop;
         speed = longint'(cfg_mirror.fast_speed);
         if (slow_rd > cfg_mirror.near_threshold) speed = longint'(cfg_mirror.slow_speed);
         if (stop_rd > cfg_mirror.near_threshold) speed = 0;
         side = s.is_left ? speed : -speed;

         mean_dev = (lv + rv) / 2 - longint'(cfg_mirror.rear_setpoint);
         fwd = clamp_mag(scale_by_gain(-mean_dev, longint'(cfg_mirror.x_gain)), FWD_LIMIT);

         gain = (speed == 0) ? longint'(cfg_mirror.yaw_gain_stopped)
                             : longint'(cfg_mirror.yaw_gain_moving);
         yaw = clamp_mag(scale_by_gain(lv - rv, gain), YAW_LIMIT);

         c.command_valid = 1'b1;
         c.vel_forward   = fwd[OUT_BITS-1:0];
         c.vel_side      = side[OUT_BITS-1:0];
         c.yaw_rate      = yaw[OUT_BITS-1:0];
         c.arrived       = (speed == 0);
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic int clip_sensor(input int v);
      return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
   endfunction

   // Pick a side reading around the threshold: at or below, above, on it, just over
   // it, or anywhere.
   function automatic logic [SENSOR_BITS-1:0] side_reading(input logic [SENSOR_BITS-1:0] thr);
      int                     t;
      logic [SENSOR_BITS-1:0] r;
      t = int'(thr);
      case ($urandom_range(4, 0))
         0: r = SENSOR_BITS'($urandom_range(t, 0));
         1: r = (t == 65535) ? FULL : SENSOR_BITS'($urandom_range(65535, t + 1));
         2: r = thr;
         3: r = (t == 65535) ? thr : thr + 16'd1;
         default: r = SENSOR_BITS'($urandom);
      endcase
      return r;
   endfunction

   // Mostly a slow approach: the rear levels drift and samples scatter around
   // them. Now and then full-range noise or the rail values.
   function automatic sample_set_type random_sample();
      sample_set_type s;
      int             mode;
      s.read_ok = ($urandom_range(9, 0) != 0);
      s.is_left = 1'($urandom_range(1, 0));
      rear_level_l = clip_sensor(rear_level_l + int'($urandom_range(2000, 0)) - 1000);
      rear_level_r = clip_sensor(rear_level_r + int'($urandom_range(2000, 0)) - 1000);
      mode = $urandom_range(9, 0);
      if (mode == 0) begin
         s.rear_left  = SENSOR_BITS'($urandom);
         s.rear_right = SENSOR_BITS'($urandom);
      end else if (mode == 1) begin
         s.rear_left  = $urandom_range(1, 0) ? FULL : NONE;
         s.rear_right = $urandom_range(1, 0) ? FULL : NONE;
      end else begin
         s.rear_left  = SENSOR_BITS'(clip_sensor(rear_level_l + int'($urandom_range(3000, 0)) - 1500));
         s.rear_right = SENSOR_BITS'(clip_sensor(rear_level_r + int'($urandom_range(3000, 0)) - 1500));
      end
      s.side_right_slow = side_reading(cfg_mirror.near_threshold);
      s.side_right_stop = side_reading(cfg_mirror.near_threshold);
      s.side_left_slow  = side_reading(cfg_mirror.near_threshold);
      s.side_left_stop  = side_reading(cfg_mirror.near_threshold);
      return s;
   endfunction

   // Present one request, hold it until accepted, then queue its command.
   // Called and returns at a falling edge.
   task automatic send_request(input sample_set_type s, input bit typed,
                               input command_type want);
      command_type predicted;
      if (!calm && $urandom_range(3, 0) == 0) begin
         req_chan_if.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(negedge clock);
      end
      req_chan_if.read_ok         <= s.read_ok;
      req_chan_if.is_left         <= s.is_left;
      req_chan_if.rear_left       <= s.rear_left;
      req_chan_if.rear_right      <= s.rear_right;
      req_chan_if.side_right_slow <= s.side_right_slow;
      req_chan_if.side_right_stop <= s.side_right_stop;
      req_chan_if.side_left_slow  <= s.side_left_slow;
      req_chan_if.side_left_stop  <= s.side_left_stop;
      req_chan_if.valid           <= 1'b1;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      // run the predictor even for typed rows so the filters stay in step
      predicted = predict_command(s);
      pending_commands.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed command has come back.
   task automatic wait_for_commands();
      req_chan_if.valid <= 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
   endtask

   // Write one tuning register; csr_we stays high for a following write.
   task automatic write_tuning_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_REAR_SETPOINT:    cfg_mirror.rear_setpoint    = val[15:0];
         REG_NEAR_THRESHOLD:   cfg_mirror.near_threshold   = val[15:0];
         REG_LEFT_OFFSET:      cfg_mirror.left_offset      = val[11:0];
         REG_FAST_SPEED:       cfg_mirror.fast_speed       = val[SPEED_BITS-1:0];
         REG_SLOW_SPEED:       cfg_mirror.slow_speed       = val[SPEED_BITS-1:0];
         REG_X_GAIN:           cfg_mirror.x_gain           = val[15:0];
         REG_YAW_GAIN_MOVING:  cfg_mirror.yaw_gain_moving  = val[16:0];
         REG_YAW_GAIN_STOPPED: cfg_mirror.yaw_gain_stopped = val[16:0];
         default: ;
      endcase
   endtask

   // Write all eight registers back to back; only call while the block is idle.
   task automatic program_tuning(input logic [CSR_DATA_BITS-1:0] target, thr, offset,
                                 fast, slow, xg, yaw_mov, yaw_stop);
      write_tuning_reg(REG_REAR_SETPOINT, target);
      write_tuning_reg(REG_NEAR_THRESHOLD, thr);
      write_tuning_reg(REG_LEFT_OFFSET, offset);
      write_tuning_reg(REG_FAST_SPEED, fast);
      write_tuning_reg(REG_SLOW_SPEED, slow);
      write_tuning_reg(REG_X_GAIN, xg);
      write_tuning_reg(REG_YAW_GAIN_MOVING, yaw_mov);
      write_tuning_reg(REG_YAW_GAIN_STOPPED, yaw_stop);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random requests under the current tuning; the last calm_tail run without idling.
   task automatic run_random(input int count, input int calm_tail);
      rear_level_l = int'($urandom_range(65535, 0));
      rear_level_r = int'($urandom_range(65535, 0));
      for (int k = 0; k < count; k++) begin
         if (k == count - calm_tail) calm = 1'b1;
         send_request(random_sample(), 1'b0, '0);
      end
      wait_for_commands();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      sample_set_type pending;
      reset                       = 1'b1;
      csr_we                      = 1'b0;
      csr_index                   = REG_REAR_SETPOINT;
      csr_wdata                   = '0;
      req_chan_if.valid           = 1'b0;
      req_chan_if.read_ok         = 1'b0;
      req_chan_if.is_left         = 1'b0;
      req_chan_if.rear_left       = '0;
      req_chan_if.rear_right      = '0;
      req_chan_if.side_right_slow = '0;
      req_chan_if.side_right_stop = '0;
      req_chan_if.side_left_slow  = '0;
      req_chan_if.side_left_stop  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under reset tuning.
      foreach (directed_rows[i]) begin
         pending.read_ok         = directed_rows[i].ok;
         pending.is_left         = directed_rows[i].left;
         pending.rear_left       = directed_rows[i].rear_l;
         pending.rear_right      = directed_rows[i].rear_r;
         pending.side_right_slow = directed_rows[i].r_slow;
         pending.side_right_stop = directed_rows[i].r_stop;
         pending.side_left_slow  = directed_rows[i].l_slow;
         pending.side_left_stop  = directed_rows[i].l_stop;
         send_request(pending, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_for_commands();

      // Every register at its top value, with bits above each width set too:
      // nothing can trigger, forward and yaw hit their clamps.
      program_tuning('1, '1, '1, '1, '1, '1, '1, '1);
      run_random(150, 0);

      // Everything zero: every nonzero reading triggers, speed and gains vanish.
      program_tuning('0, '0, '0, '0, '0, '0, '0, '0);
      run_random(150, 0);

      // Reset tuning, the long realistic stretch.
      program_tuning(17'd13500, 17'd10000, 17'd800, 17'd5325, 17'd1229,
                     17'd53687, 17'd32768, 17'd61441);
      run_random(500, 0);

      // Random tuning, full 17-bit write data so the masking is exercised.
      program_tuning(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                     17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
      run_random(350, 0);

      // Zero slow speed: a slow trigger alone stops; stopped yaw gain is zero.
      program_tuning(17'd30000, 17'd2000, 17'd4095, 17'd8191, 17'd0,
                     17'd65535, 17'd131071, 17'd0);
      run_random(150, 0);

      program_tuning(17'($urandom), 17'($urandom_range(20000, 0)), 17'($urandom),
                     17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                     17'($urandom));
      run_random(150, 0);

      // Back to reset tuning; finish with both sides running flat out.
      program_tuning(17'd13500, 17'd10000, 17'd800, 17'd5325, 17'd1229,
                     17'd53687, 17'd32768, 17'd61441);
      run_random(400, 250);

      // Hold for a drain period to catch any stray response.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_wall_approach_velocity_controller passed");
      end else begin
         $display("tb_wall_approach_velocity_controller failed");
      end
      $finish;
   end

   // Response side: ready in random runs broken by random stall bursts,
   // occasionally a long run with no stall, and always ready once calm.
   initial begin
      int run_len;
      rsp_chan_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run_len = ($urandom_range(3, 0) == 0) ? int'($urandom_range(80, 30))
                                               : int'($urandom_range(12, 1));
         rsp_chan_if.ready <= 1'b1;
         repeat (calm ? 1 : run_len) @(negedge clock);
         if (!calm) begin
            rsp_chan_if.ready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted response with the oldest owed command.
   always @(posedge clock) begin
      command_type want;
      if (!reset && rsp_chan_if.valid && rsp_chan_if.ready) begin
         if (pending_commands.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_commands.pop_front();
            compare_field("command_valid", 32'(want.command_valid),
                          32'(rsp_chan_if.command_valid));
            compare_field("vel_forward", 32'(want.vel_forward), 32'(rsp_chan_if.vel_forward));
            compare_field("vel_side", 32'(want.vel_side), 32'(rsp_chan_if.vel_side));
            compare_field("yaw_rate", 32'(want.yaw_rate), 32'(rsp_chan_if.yaw_rate));
            compare_field("arrived", 32'(want.arrived), 32'(rsp_chan_if.arrived));
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_wall_approach_velocity_controller failed");
         $finish;
      end
   end

endmodule
